// ===== rtl/pimrp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pimrp_pkg
// Shared types, codes and the multiply sequence of the ray parity unit.
// ----------------------------------------------------------------------------
package pimrp_pkg;

    localparam int DEF_MAX_FACES   = 1024;
    localparam int DEF_COORD_WIDTH = 32;

    localparam int FACE_COUNT_W = 11;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;
    localparam int IN_DATA_W    = 304;
    localparam int OUT_DATA_W   = 16;
    localparam int FIELD_W      = 32;
    localparam int SLOT_W       = 10;
    localparam int LIMIT_W      = 63;
    localparam int STEP_W       = 5;

    localparam logic [STEP_W-1:0] STEP_LAST  = 5'd15;
    localparam logic [STEP_W-1:0] STEP_DRAIN = 5'd16;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FACE_COUNT,
        REG_BOX_MIN_X,
        REG_BOX_MIN_Y,
        REG_BOX_MIN_Z,
        REG_BOX_MAX_X,
        REG_BOX_MAX_Y,
        REG_BOX_MAX_Z,
        REG_PARALLEL_LIMIT
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BOX,
        ST_READ,
        ST_EDGE,
        ST_MUL,
        ST_FIX,
        ST_TEST,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        OPD_E1X,
        OPD_E1Y,
        OPD_E1Z,
        OPD_E2X,
        OPD_E2Y,
        OPD_E2Z,
        OPD_S0,
        OPD_S1,
        OPD_S2,
        OPD_CX_LO,
        OPD_CX_HI,
        OPD_CY_LO,
        OPD_CY_HI,
        OPD_CZ_LO,
        OPD_CZ_HI
    } opd_t;

    typedef enum logic [2:0] {
        DST_NONE,
        DST_CX,
        DST_CY,
        DST_CZ,
        DST_NU,
        DST_NV,
        DST_NT
    } dst_t;

    typedef struct packed {
        opd_t a_sel;
        opd_t b_sel;
        logic shift;
        logic clr;
        logic sub;
        dst_t dst;
    } step_ctl_t;

    // cross products, raw u and v numerators, then t numerator from split
    // cross product halves
    function automatic step_ctl_t step_ctl(input logic [STEP_W-1:0] step);
        step_ctl_t c;
        c = '{a_sel: OPD_E1Y, b_sel: OPD_E2Z, shift: 1'b0, clr: 1'b1,
              sub: 1'b0, dst: DST_NONE};
        unique case (step)
            5'd0:  c = '{OPD_E1Y, OPD_E2Z,   1'b0, 1'b1, 1'b0, DST_NONE};
            5'd1:  c = '{OPD_E1Z, OPD_E2Y,   1'b0, 1'b0, 1'b1, DST_CX};
            5'd2:  c = '{OPD_E1Z, OPD_E2X,   1'b0, 1'b1, 1'b0, DST_NONE};
            5'd3:  c = '{OPD_E1X, OPD_E2Z,   1'b0, 1'b0, 1'b1, DST_CY};
            5'd4:  c = '{OPD_E1X, OPD_E2Y,   1'b0, 1'b1, 1'b0, DST_NONE};
            5'd5:  c = '{OPD_E1Y, OPD_E2X,   1'b0, 1'b0, 1'b1, DST_CZ};
            5'd6:  c = '{OPD_S1,  OPD_E2Z,   1'b0, 1'b1, 1'b0, DST_NONE};
            5'd7:  c = '{OPD_S2,  OPD_E2Y,   1'b0, 1'b0, 1'b1, DST_NU};
            5'd8:  c = '{OPD_E1Y, OPD_S2,    1'b0, 1'b1, 1'b0, DST_NONE};
            5'd9:  c = '{OPD_E1Z, OPD_S1,    1'b0, 1'b0, 1'b1, DST_NV};
            5'd10: c = '{OPD_S0,  OPD_CX_LO, 1'b0, 1'b1, 1'b0, DST_NONE};
            5'd11: c = '{OPD_S0,  OPD_CX_HI, 1'b1, 1'b0, 1'b0, DST_NONE};
            5'd12: c = '{OPD_S1,  OPD_CY_LO, 1'b0, 1'b0, 1'b0, DST_NONE};
            5'd13: c = '{OPD_S1,  OPD_CY_HI, 1'b1, 1'b0, 1'b0, DST_NONE};
            5'd14: c = '{OPD_S2,  OPD_CZ_LO, 1'b0, 1'b0, 1'b0, DST_NONE};
            5'd15: c = '{OPD_S2,  OPD_CZ_HI, 1'b1, 1'b0, 1'b0, DST_NT};
            default: c = '{OPD_E1Y, OPD_E2Z, 1'b0, 1'b1, 1'b0, DST_NONE};
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/point_in_mesh_ray_parity_unit.sv =====
`default_nettype none
// A load item writes one triangle into the face store and gives no result. A
// query item reads N faces before its result is offered, N being face_count
// limited to MAX_FACES (none when the bounding box rejects the point). Each
// face passes through one store read, one edge setup, sixteen products
// through the one shared multiplier plus a drain step, a sign fix-up and the
// hit test. The input side is not ready while a query is at work. The face
// store has no reset: querying a slot never loaded gives an undefined count.
// ----------------------------------------------------------------------------
// point_in_mesh_ray_parity_unit
// Point in triangle mesh test by +x ray crossing parity.
// ----------------------------------------------------------------------------
module point_in_mesh_ray_parity_unit #(
    parameter int MAX_FACES   = pimrp_pkg::DEF_MAX_FACES,
    parameter int COORD_WIDTH = pimrp_pkg::DEF_COORD_WIDTH
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire  [pimrp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [pimrp_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire                                   s_axis_tvalid,
    output logic                                  s_axis_tready,
    // face_slot, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, zero pad
    input  wire  [pimrp_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // func
    input  wire                                   s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    // inside_res, crossings, zero pad
    output logic [pimrp_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // box_rejected
    output logic                                  m_axis_tuser
);

    localparam int CW     = COORD_WIDTH;
    localparam int D_W    = CW + 1;
    localparam int C_W    = 2 * D_W + 1;
    localparam int LO_W   = D_W;
    localparam int MW     = D_W + 1;
    localparam int PW     = 2 * MW;
    localparam int NT_W   = 3 * D_W + 3;
    localparam int TST_W  = C_W + 2;
    localparam int CMP_W  = (C_W > pimrp_pkg::LIMIT_W) ? C_W : pimrp_pkg::LIMIT_W;
    localparam int AW     = $clog2(MAX_FACES);
    localparam int FW     = $clog2(MAX_FACES + 1);
    localparam int ROW_W  = 9 * CW;
    localparam int SEXT_W = 17;

    // configuration
    logic [pimrp_pkg::FACE_COUNT_W-1:0]  face_count_reg;
    logic signed [31:0]                  box_min_reg [3];
    logic signed [31:0]                  box_max_reg [3];
    logic [pimrp_pkg::LIMIT_W-1:0]       parallel_limit_reg;

    // control
    pimrp_pkg::state_t state_reg, state_next;
    logic [pimrp_pkg::STEP_W-1:0] step_reg, step_next;
    logic [FW-1:0] face_idx_reg, face_idx_next;
    logic [FW-1:0] hits_reg, hits_next;
    logic          rej_reg, rej_next;
    logic          out_valid_reg, out_valid_next;
    logic          mul_vld_reg;

    logic pt_load, edge_load, mul_issue, fix_load, out_load;

    // datapath
    logic [ROW_W-1:0]          face_mem [MAX_FACES];
    logic [ROW_W-1:0]          in_row;
    logic [ROW_W-1:0]          rd_row_reg;
    logic [SEXT_W-1:0]         slot_ext;
    logic                      mem_we;
    logic signed [CW-1:0]      pt_reg [3];
    logic signed [D_W-1:0]     e1_reg [3];
    logic signed [D_W-1:0]     e2_reg [3];
    logic signed [D_W-1:0]     s_reg  [3];
    logic signed [MW-1:0]      mul_a, mul_b;
    logic signed [PW-1:0]      prod_reg;
    pimrp_pkg::step_ctl_t      mul_ctl_reg;
    logic signed [NT_W-1:0]    acc_reg, acc_base, acc_term, acc_next;
    logic signed [C_W-1:0]     cx_reg, cy_reg, cz_reg, nu_reg, nv_reg;
    logic signed [NT_W-1:0]    nt_reg;
    logic                      det_zero_reg, nt_neg_reg;
    logic signed [C_W-1:0]     det_abs_reg, nu_c_reg, nv_c_reg;
    logic                      out_inside_reg, out_rej_reg;
    logic [pimrp_pkg::FACE_COUNT_W-1:0] out_cross_reg;

    logic                      in_box;
    logic [SEXT_W-1:0]         fc_ext;
    logic [FW-1:0]             n_faces;
    logic                      flip;
    logic [CMP_W-1:0]          det_u, lim_u;
    logic signed [TST_W-1:0]   rem;
    logic                      hit;
    logic signed [D_W-1:0]     coord_a [3];
    logic signed [D_W-1:0]     coord_b [3];
    logic signed [D_W-1:0]     coord_c [3];

    assign cfg_ready = 1'b1;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            in_row[i*CW +: CW] =
                s_axis_tdata[pimrp_pkg::SLOT_W + pimrp_pkg::FIELD_W*i +: CW];
        end
    end

    assign slot_ext = SEXT_W'(s_axis_tdata[pimrp_pkg::SLOT_W-1:0]);
    assign mem_we   = s_axis_tvalid && s_axis_tready
                      && (s_axis_tuser == pimrp_pkg::FUNC_LOAD)
                      && (slot_ext < SEXT_W'(MAX_FACES));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            face_mem[slot_ext[AW-1:0]] <= in_row;
        end
        rd_row_reg <= face_mem[face_idx_reg[AW-1:0]];
    end

    always_comb
    begin
        in_box = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            if (32'(pt_reg[i]) < box_min_reg[i] || 32'(pt_reg[i]) > box_max_reg[i])
            begin
                in_box = 1'b0;
            end
        end
    end

    assign fc_ext  = SEXT_W'(face_count_reg);
    assign n_faces = (fc_ext > SEXT_W'(MAX_FACES)) ? FW'(MAX_FACES) : fc_ext[FW-1:0];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            coord_a[i] = D_W'(signed'(rd_row_reg[i*CW +: CW]));
            coord_b[i] = D_W'(signed'(rd_row_reg[(3+i)*CW +: CW]));
            coord_c[i] = D_W'(signed'(rd_row_reg[(6+i)*CW +: CW]));
        end
    end

    // shared multiplier operands
    always_comb
    begin
        pimrp_pkg::step_ctl_t c;
        c = pimrp_pkg::step_ctl(step_reg);
        unique case (c.a_sel)
            pimrp_pkg::OPD_E1X: mul_a = MW'(e1_reg[0]);
            pimrp_pkg::OPD_E1Y: mul_a = MW'(e1_reg[1]);
            pimrp_pkg::OPD_E1Z: mul_a = MW'(e1_reg[2]);
            pimrp_pkg::OPD_S0:  mul_a = MW'(s_reg[0]);
            pimrp_pkg::OPD_S1:  mul_a = MW'(s_reg[1]);
            pimrp_pkg::OPD_S2:  mul_a = MW'(s_reg[2]);
            default:            mul_a = '0;
        endcase
        unique case (c.b_sel)
            pimrp_pkg::OPD_E2X:   mul_b = MW'(e2_reg[0]);
            pimrp_pkg::OPD_E2Y:   mul_b = MW'(e2_reg[1]);
            pimrp_pkg::OPD_E2Z:   mul_b = MW'(e2_reg[2]);
            pimrp_pkg::OPD_S1:    mul_b = MW'(s_reg[1]);
            pimrp_pkg::OPD_S2:    mul_b = MW'(s_reg[2]);
            pimrp_pkg::OPD_CX_LO: mul_b = signed'({1'b0, cx_reg[LO_W-1:0]});
            pimrp_pkg::OPD_CX_HI: mul_b = signed'(cx_reg[C_W-1:LO_W]);
            pimrp_pkg::OPD_CY_LO: mul_b = signed'({1'b0, cy_reg[LO_W-1:0]});
            pimrp_pkg::OPD_CY_HI: mul_b = signed'(cy_reg[C_W-1:LO_W]);
            pimrp_pkg::OPD_CZ_LO: mul_b = signed'({1'b0, cz_reg[LO_W-1:0]});
            pimrp_pkg::OPD_CZ_HI: mul_b = signed'(cz_reg[C_W-1:LO_W]);
            default:              mul_b = '0;
        endcase
    end

    always_comb
    begin
        acc_base = mul_ctl_reg.clr ? '0 : acc_reg;
        acc_term = mul_ctl_reg.shift ? (NT_W'(prod_reg) <<< LO_W) : NT_W'(prod_reg);
        acc_next = mul_ctl_reg.sub ? (acc_base - acc_term) : (acc_base + acc_term);
    end

    // det = -cx; flip when det is negative
    assign flip = !cx_reg[C_W-1] && (cx_reg != '0);

    assign det_u = CMP_W'(unsigned'(det_abs_reg));
    assign lim_u = CMP_W'(parallel_limit_reg);
    assign rem   = TST_W'(det_abs_reg) - TST_W'(nu_c_reg) - TST_W'(nv_c_reg);
    assign hit   = !det_zero_reg && (det_u >= lim_u) && !nt_neg_reg
                   && !nu_c_reg[C_W-1] && !nv_c_reg[C_W-1] && !rem[TST_W-1];

    always_ff @(posedge clk)
    begin
        if (pt_load)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pt_reg[i] <= signed'(s_axis_tdata[pimrp_pkg::SLOT_W
                                     + pimrp_pkg::FIELD_W*i +: CW]);
            end
        end
        if (edge_load)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e1_reg[i] <= coord_b[i] - coord_a[i];
                e2_reg[i] <= coord_c[i] - coord_a[i];
                s_reg[i]  <= D_W'(pt_reg[i]) - coord_a[i];
            end
        end
        prod_reg    <= mul_a * mul_b;
        mul_ctl_reg <= pimrp_pkg::step_ctl(step_reg);
        if (mul_vld_reg)
        begin
            acc_reg <= acc_next;
            unique case (mul_ctl_reg.dst)
                pimrp_pkg::DST_CX: cx_reg <= acc_next[C_W-1:0];
                pimrp_pkg::DST_CY: cy_reg <= acc_next[C_W-1:0];
                pimrp_pkg::DST_CZ: cz_reg <= acc_next[C_W-1:0];
                pimrp_pkg::DST_NU: nu_reg <= acc_next[C_W-1:0];
                pimrp_pkg::DST_NV: nv_reg <= acc_next[C_W-1:0];
                pimrp_pkg::DST_NT: nt_reg <= acc_next;
                default:           ;
            endcase
        end
        if (fix_load)
        begin
            det_zero_reg <= (cx_reg == '0);
            det_abs_reg  <= flip ? cx_reg : -cx_reg;
            nu_c_reg     <= flip ? nu_reg : -nu_reg;
            nv_c_reg     <= flip ? nv_reg : -nv_reg;
            nt_neg_reg   <= flip ? ((nt_reg != '0) && !nt_reg[NT_W-1]) : nt_reg[NT_W-1];
        end
        if (out_load)
        begin
            out_inside_reg <= hits_reg[0] && !rej_reg;
            out_cross_reg  <= pimrp_pkg::FACE_COUNT_W'(hits_reg);
            out_rej_reg    <= rej_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        face_idx_next  = face_idx_reg;
        hits_next      = hits_reg;
        rej_next       = rej_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        s_axis_tready  = 1'b0;
        pt_load        = 1'b0;
        edge_load      = 1'b0;
        mul_issue      = 1'b0;
        fix_load       = 1'b0;
        out_load       = 1'b0;
        unique case (state_reg)
            pimrp_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid && s_axis_tuser == pimrp_pkg::FUNC_QUERY)
                begin
                    pt_load    = 1'b1;
                    state_next = pimrp_pkg::ST_BOX;
                end
            end
            pimrp_pkg::ST_BOX:
            begin
                hits_next     = '0;
                face_idx_next = '0;
                rej_next      = !in_box;
                state_next    = (!in_box || n_faces == '0) ? pimrp_pkg::ST_DONE
                                                            : pimrp_pkg::ST_READ;
            end
            pimrp_pkg::ST_READ:
            begin
                state_next = pimrp_pkg::ST_EDGE;
            end
            pimrp_pkg::ST_EDGE:
            begin
                edge_load  = 1'b1;
                step_next  = '0;
                state_next = pimrp_pkg::ST_MUL;
            end
            pimrp_pkg::ST_MUL:
            begin
                mul_issue = (step_reg <= pimrp_pkg::STEP_LAST);
                step_next = step_reg + 1'b1;
                if (step_reg == pimrp_pkg::STEP_DRAIN)
                begin
                    state_next = pimrp_pkg::ST_FIX;
                end
            end
            pimrp_pkg::ST_FIX:
            begin
                fix_load   = 1'b1;
                state_next = pimrp_pkg::ST_TEST;
            end
            pimrp_pkg::ST_TEST:
            begin
                hits_next     = hits_reg + FW'(hit);
                face_idx_next = face_idx_reg + 1'b1;
                state_next    = (face_idx_reg + 1'b1 == n_faces) ? pimrp_pkg::ST_DONE
                                                                 : pimrp_pkg::ST_READ;
            end
            pimrp_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_load       = 1'b1;
                    state_next     = pimrp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pimrp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= pimrp_pkg::ST_IDLE;
            step_reg           <= '0;
            face_idx_reg       <= '0;
            hits_reg           <= '0;
            rej_reg            <= 1'b0;
            out_valid_reg      <= 1'b0;
            mul_vld_reg        <= 1'b0;
            face_count_reg     <= '0;
            parallel_limit_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                box_min_reg[i] <= '0;
                box_max_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            face_idx_reg  <= face_idx_next;
            hits_reg      <= hits_next;
            rej_reg       <= rej_next;
            out_valid_reg <= out_valid_next;
            mul_vld_reg   <= mul_issue;
            if (cfg_valid)
            begin
                unique case (pimrp_pkg::cfg_reg_t'(cfg_index))
                    pimrp_pkg::REG_FACE_COUNT: face_count_reg <= cfg_data[10:0];
                    pimrp_pkg::REG_BOX_MIN_X:  box_min_reg[0] <= signed'(cfg_data[31:0]);
                    pimrp_pkg::REG_BOX_MIN_Y:  box_min_reg[1] <= signed'(cfg_data[31:0]);
                    pimrp_pkg::REG_BOX_MIN_Z:  box_min_reg[2] <= signed'(cfg_data[31:0]);
                    pimrp_pkg::REG_BOX_MAX_X:  box_max_reg[0] <= signed'(cfg_data[31:0]);
                    pimrp_pkg::REG_BOX_MAX_Y:  box_max_reg[1] <= signed'(cfg_data[31:0]);
                    pimrp_pkg::REG_BOX_MAX_Z:  box_max_reg[2] <= signed'(cfg_data[31:0]);
                    pimrp_pkg::REG_PARALLEL_LIMIT:
                        parallel_limit_reg <= cfg_data[62:0];
                    default: ;
                endcase
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_cross_reg, out_inside_reg};
    assign m_axis_tuser  = out_rej_reg;

    a_hits_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pimrp_pkg::ST_TEST |-> hits_reg <= face_idx_reg)
        else $error("hit count above faces tested");

    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("rejected item carries crossings");

    a_parity: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[0] == m_axis_tdata[1])
        else $error("inside flag disagrees with crossing parity");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pimrp_pkg::ST_MUL |-> step_reg <= pimrp_pkg::STEP_DRAIN)
        else $error("multiply step out of range");

    a_mul_origin: assert property (@(posedge clk) disable iff (!rst_n)
        mul_vld_reg |-> $past(state_reg) == pimrp_pkg::ST_MUL)
        else $error("product accumulated outside multiply phase");

endmodule
`default_nettype wire

// ===== tb/point_in_mesh_ray_parity_unit_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// point_in_mesh_ray_parity_unit_check
// Watches the configuration, input and result channels of the ray parity
// unit, keeps its own copy of the face store and registers, works out the
// verdict of every accepted query and compares it with the result stream.
// ----------------------------------------------------------------------------
module point_in_mesh_ray_parity_unit_check
(
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_valid,
    input  wire                                cfg_ready,
    input  wire  [pimrp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [pimrp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire                                s_axis_tvalid,
    input  wire                                s_axis_tready,
    input  wire  [pimrp_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input  wire                                s_axis_tuser,
    input  wire                                m_axis_tvalid,
    input  wire                                m_axis_tready,
    input  wire  [pimrp_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  wire                                m_axis_tuser,
    output int                                 errors,
    output int                                 awaiting,
    output int                                 checked,
    output int                                 rejected_cnt,
    output int                                 inside_cnt
);

    localparam int NFACES = pimrp_pkg::DEF_MAX_FACES;

    typedef struct packed {
        logic        in_mesh;
        logic [10:0] crossings;
        logic        rejected;
    } verdict_t;

    logic signed [31:0]              face_mem [NFACES][9];
    logic [10:0]                     face_cnt;
    logic signed [31:0]              box_lo [3];
    logic signed [31:0]              box_hi [3];
    logic [pimrp_pkg::LIMIT_W-1:0]   det_floor;
    verdict_t                        verdicts_q [$];

    function automatic logic signed [127:0] mul_wide(input longint x, input longint y);
        logic signed [127:0] wx;
        logic signed [127:0] wy;
        wx = x;
        wy = y;
        return wx * wy;
    endfunction

    function automatic bit ray_crosses(input logic signed [31:0] p [3], input int f);
        longint e1 [3];
        longint e2 [3];
        longint s [3];
        logic signed [127:0] cx, cy, cz, det, nu, nv, nt, floor_w;
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = longint'(face_mem[f][3+i]) - longint'(face_mem[f][i]);
            e2[i] = longint'(face_mem[f][6+i]) - longint'(face_mem[f][i]);
            s[i]  = longint'(p[i]) - longint'(face_mem[f][i]);
        end
        cx  = mul_wide(e1[1], e2[2]) - mul_wide(e1[2], e2[1]);
        cy  = mul_wide(e1[2], e2[0]) - mul_wide(e1[0], e2[2]);
        cz  = mul_wide(e1[0], e2[1]) - mul_wide(e1[1], e2[0]);
        det = -cx;
        nu  = -(mul_wide(s[1], e2[2]) - mul_wide(s[2], e2[1]));
        nv  = -(mul_wide(e1[1], s[2]) - mul_wide(e1[2], s[1]));
        nt  = mul_wide(s[0], 1) * cx + mul_wide(s[1], 1) * cy + mul_wide(s[2], 1) * cz;
        if (det == 0)
            return 1'b0;
        if (det < 0)
        begin
            det = -det;
            nu  = -nu;
            nv  = -nv;
            nt  = -nt;
        end
        floor_w = $signed({65'd0, det_floor});
        if (det < floor_w)
            return 1'b0;
        if (nt < 0 || nu < 0 || nv < 0)
            return 1'b0;
        if (det - (nu + nv) < 0)
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic verdict_t locate_point(input logic signed [31:0] p [3]);
        verdict_t v;
        int n;
        int hits;
        v = '0;
        hits = 0;
        for (int i = 0; i < 3; i++)
            if (p[i] < box_lo[i] || p[i] > box_hi[i])
                v.rejected = 1'b1;
        if (v.rejected)
            return v;
        n = (face_cnt > NFACES) ? NFACES : int'(face_cnt);
        for (int f = 0; f < n; f++)
            if (ray_crosses(p, f))
                hits++;
        v.in_mesh   = hits[0];
        v.crossings = hits[10:0];
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [31:0] pt [3];
        verdict_t want;
        verdict_t got;
        if (!rst_n)
        begin
            face_cnt  = '0;
            det_floor = '0;
            for (int i = 0; i < 3; i++)
            begin
                box_lo[i] = '0;
                box_hi[i] = '0;
            end
            verdicts_q.delete();
            errors = 0;
            checked = 0;
            rejected_cnt = 0;
            inside_cnt = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.in_mesh   = m_axis_tdata[0];
                got.crossings = m_axis_tdata[11:1];
                got.rejected  = m_axis_tuser;
                checked++;
                if (verdicts_q.size() == 0)
                begin
                    errors++;
                    $display("%t: unexpected result in_mesh=%0d crossings=%0d rejected=%0d",
                             $realtime, got.in_mesh, got.crossings, got.rejected);
                end
                else
                begin
                    want = verdicts_q.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        $display("%t: mismatch, expected in_mesh=%0d crossings=%0d rejected=%0d",
                                 $realtime, want.in_mesh, want.crossings, want.rejected);
                        $display("%t: mismatch, actual in_mesh=%0d crossings=%0d rejected=%0d",
                                 $realtime, got.in_mesh, got.crossings, got.rejected);
                    end
                    rejected_cnt += want.rejected;
                    inside_cnt   += want.in_mesh;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (pimrp_pkg::cfg_reg_t'(cfg_index))
                    pimrp_pkg::REG_FACE_COUNT:     face_cnt  = cfg_data[10:0];
                    pimrp_pkg::REG_BOX_MIN_X:      box_lo[0] = cfg_data[31:0];
                    pimrp_pkg::REG_BOX_MIN_Y:      box_lo[1] = cfg_data[31:0];
                    pimrp_pkg::REG_BOX_MIN_Z:      box_lo[2] = cfg_data[31:0];
                    pimrp_pkg::REG_BOX_MAX_X:      box_hi[0] = cfg_data[31:0];
                    pimrp_pkg::REG_BOX_MAX_Y:      box_hi[1] = cfg_data[31:0];
                    pimrp_pkg::REG_BOX_MAX_Z:      box_hi[2] = cfg_data[31:0];
                    pimrp_pkg::REG_PARALLEL_LIMIT:
                        det_floor = cfg_data[pimrp_pkg::LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser == pimrp_pkg::FUNC_LOAD)
                begin
                    for (int k = 0; k < 9; k++)
                        face_mem[s_axis_tdata[9:0]][k] = s_axis_tdata[10 + 32*k +: 32];
                end
                else
                begin
                    for (int k = 0; k < 3; k++)
                        pt[k] = s_axis_tdata[10 + 32*k +: 32];
                    verdicts_q.insert(verdicts_q.size(), locate_point(pt));
                end
            end
        end
        awaiting = verdicts_q.size();
    end

endmodule

// ===== tb/point_in_mesh_ray_parity_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// point_in_mesh_ray_parity_unit_test
// Loads triangle meshes and sends query points through the ray parity unit
// under a series of box, face count and determinant limit settings, with
// random gaps on the input side and random stalls on the result side. A
// separate checker predicts and compares every verdict.
// ----------------------------------------------------------------------------
module point_in_mesh_ray_parity_unit_test;

    localparam int U         = 65536;
    localparam int IDLE_STOP = 100000;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [pimrp_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [pimrp_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [pimrp_pkg::IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic                              s_axis_tuser = 1'b0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [pimrp_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
    logic                              m_axis_tuser;

    int errors, awaiting, checked, rejected_cnt, inside_cnt;
    int n_loads = 0;
    int n_queries = 0;
    int n_settings = 0;
    int loaded = 0;
    int idle_cycles = 0;
    int rdy_run = 0;
    int rdy_mode = 0;

    always #6 clk = ~clk;

    point_in_mesh_ray_parity_unit i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    point_in_mesh_ray_parity_unit_check i_check (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .errors(errors), .awaiting(awaiting), .checked(checked),
        .rejected_cnt(rejected_cnt), .inside_cnt(inside_cnt)
    );

    // result side back-pressure in stretches
    always @(negedge clk)
    begin
        if (rdy_run == 0)
        begin
            rdy_run  = $urandom_range(1, 40);
            rdy_mode = $urandom_range(0, 3);
        end
        rdy_run--;
        case (rdy_mode)
            0:       m_axis_tready = 1'b1;
            3:       m_axis_tready = ($urandom_range(0, 9) == 0);
            default: m_axis_tready = ($urandom_range(0, 2) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if ((cfg_valid && cfg_ready) || (s_axis_tvalid && s_axis_tready)
            || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_STOP)
        begin
            $display("%t: no progress for %0d cycles", $realtime, IDLE_STOP);
            $display("[point_in_mesh_ray_parity_unit] ERROR");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int near_coord(input int span);
        return int'($urandom_range(0, 2 * span * U)) - span * U;
    endfunction

    task automatic reg_write(input pimrp_pkg::cfg_reg_t idx, input logic [63:0] value);
        repeat (gap_len()) @(negedge clk);
        cfg_index = idx;
        cfg_data  = value;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_item(input logic fn, input logic [pimrp_pkg::SLOT_W-1:0] slot,
                             input int c [9]);
        logic [pimrp_pkg::IN_DATA_W-1:0] d;
        d = '0;
        d[9:0] = slot;
        for (int k = 0; k < 9; k++)
            d[10 + 32*k +: 32] = c[k];
        repeat (gap_len()) @(negedge clk);
        s_axis_tdata  = d;
        s_axis_tuser  = fn;
        s_axis_tvalid = 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        if (fn == pimrp_pkg::FUNC_LOAD)
            n_loads++;
        else
            n_queries++;
    endtask

    task automatic query(input int x, input int y, input int z);
        int c [9];
        c[0] = x;
        c[1] = y;
        c[2] = z;
        for (int k = 3; k < 9; k++)
            c[k] = $urandom;
        send_item(pimrp_pkg::FUNC_QUERY, pimrp_pkg::SLOT_W'($urandom_range(0, 1023)), c);
    endtask

    task automatic load_random_face(input int slot);
        int c [9];
        bit full;
        full = ($urandom_range(0, 99) < 15);
        for (int k = 0; k < 9; k++)
            c[k] = full ? int'($urandom) : near_coord(8);
        send_item(pimrp_pkg::FUNC_LOAD, pimrp_pkg::SLOT_W'(slot), c);
    endtask

    task automatic load_face(input int slot, input int ax, input int ay, input int az,
                             input int bx, input int by, input int bz,
                             input int cx, input int cy, input int cz);
        int c [9];
        c = '{ax * U, ay * U, az * U, bx * U, by * U, bz * U, cx * U, cy * U, cz * U};
        send_item(pimrp_pkg::FUNC_LOAD, pimrp_pkg::SLOT_W'(slot), c);
    endtask

    task automatic settle();
        @(posedge clk);
        while (awaiting != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_all(input int fc, input int lo [3], input int hi [3],
                           input logic [63:0] lim);
        reg_write(pimrp_pkg::REG_FACE_COUNT, 64'(fc));
        reg_write(pimrp_pkg::REG_BOX_MIN_X, 64'(lo[0]));
        reg_write(pimrp_pkg::REG_BOX_MIN_Y, 64'(lo[1]));
        reg_write(pimrp_pkg::REG_BOX_MIN_Z, 64'(lo[2]));
        reg_write(pimrp_pkg::REG_BOX_MAX_X, 64'(hi[0]));
        reg_write(pimrp_pkg::REG_BOX_MAX_Y, 64'(hi[1]));
        reg_write(pimrp_pkg::REG_BOX_MAX_Z, 64'(hi[2]));
        reg_write(pimrp_pkg::REG_PARALLEL_LIMIT, lim);
        n_settings++;
    endtask

    initial
    begin
        int lo [3];
        int hi [3];
        int fc;
        int r;
        int ax;
        logic [63:0] lim;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // tetrahedron; its base lies parallel to the ray
        lo = '{-32 * U, -32 * U, -32 * U};
        hi = '{32 * U, 32 * U, 32 * U};
        set_all(4, lo, hi, 0);
        load_face(0, 0, 0, 0, 4, 0, 0, 0, 4, 0);
        load_face(1, 0, 0, 0, 0, 4, 0, 0, 0, 4);
        load_face(2, 0, 0, 0, 0, 0, 4, 4, 0, 0);
        load_face(3, 4, 0, 0, 0, 4, 0, 0, 0, 4);
        loaded = 4;
        query(U, U, U);
        query(-U, U, U);
        query(100 * U, 0, 0);
        query(32 * U, 32 * U, 32 * U);
        query(-32 * U, -32 * U, -32 * U);
        query(32 * U + 1, 0, 0);
        query(0, 0, 0);
        query(2 * U, 0, 2 * U);
        settle();
        set_all(4, lo, hi, 64'h7fff_ffff_ffff_ffff);
        query(U, U, U);
        settle();
        // full range box and coordinates
        lo = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        hi = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
        set_all(4, lo, hi, 0);
        send_item(pimrp_pkg::FUNC_LOAD, 10'h3ff,
                  '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                    32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff});
        load_random_face(2);
        query(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        query(32'h8000_0000, 0, 0);
        settle();
        set_all(0, lo, hi, 0);
        query(U, U, U);
        settle();
        lo = '{5 * U, -U, -U};
        hi = '{-5 * U, U, U};
        set_all(4, lo, hi, 0);
        query(0, 0, 0);
        settle();

        while (n_loads + n_queries < 560)
        begin
            r = $urandom_range(0, 99);
            fc = (r < 10) ? 0 : (r < 85) ? $urandom_range(1, 12) : $urandom_range(13, 48);
            for (int k = 0; k < 3; k++)
            begin
                lo[k] = -$urandom_range(2, 12) * U;
                hi[k] = $urandom_range(2, 12) * U;
            end
            r = $urandom_range(0, 99);
            if (r >= 70 && r < 85)
            begin
                lo = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
                hi = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
            end
            else if (r >= 85 && r < 95)
            begin
                ax = $urandom_range(0, 2);
                lo[ax] = 5 * U;
                hi[ax] = -5 * U;
            end
            else if (r >= 95)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    lo[k] = $urandom;
                    hi[k] = $urandom;
                end
            end
            r = $urandom_range(0, 99);
            if (r < 50)
                lim = 0;
            else if (r < 80)
                lim = {$urandom, $urandom} >> $urandom_range(1, 40);
            else if (r < 95)
                lim = {$urandom, $urandom} >> 1;
            else
                lim = 64'h7fff_ffff_ffff_ffff;
            set_all(fc, lo, hi, lim);
            while (loaded < fc)
            begin
                load_random_face(loaded);
                loaded++;
            end
            repeat ($urandom_range(8, 30))
            begin
                if (loaded > 0 && $urandom_range(0, 99) < 20)
                    load_random_face($urandom_range(0, loaded - 1));
                else if ($urandom_range(0, 99) < 85)
                    query(near_coord(9), near_coord(9), near_coord(9));
                else
                    query($urandom, $urandom, $urandom);
            end
            settle();
        end

        $display("Sent %0d loads and %0d queries over %0d register settings.",
                 n_loads, n_queries, n_settings);
        $display("Checked %0d results: %0d box rejections, %0d inside verdicts.",
                 checked, rejected_cnt, inside_cnt);
        if (errors == 0)
            $display("[point_in_mesh_ray_parity_unit] OK");
        else
            $display("[point_in_mesh_ray_parity_unit] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/pimrp_pkg.sv
rtl/point_in_mesh_ray_parity_unit.sv
tb/point_in_mesh_ray_parity_unit_check.sv
tb/point_in_mesh_ray_parity_unit_test.sv
